@@ hdl/nosc_pkg.sv @@
package nosc_pkg;

	// Default buffer depth per string
	localparam int DEF_MAX_LEN = 64;

	// Depth of the queue between command intake and compare engine
	localparam int QDEPTH = 4;

	// Command codes on the request port
	localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
	localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
	localparam logic [1:0] CMD_COMPARE       = 2'd2;

	// Order codes on the result port
	localparam logic [1:0] ORD_LT = 2'b11;
	localparam logic [1:0] ORD_EQ = 2'b00;
	localparam logic [1:0] ORD_GT = 2'b01;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] character;
	} req_t;

	typedef struct packed {
		logic signed [1:0] order;
		logic              truncated;
	} res_t;

	typedef enum logic [1:0] {
		OP_APPEND_A = 2'd0,
		OP_APPEND_B = 2'd1,
		OP_COMPARE  = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] ch;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} q_head_t;

endpackage

@@ hdl/nosc_front.sv @@
module nosc_front import nosc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  req_t    request,
	output logic    busy,
	input  logic    take,
	output q_head_t head
);

	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	op_t            fifo_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	op_kind_t       push_kind;
	logic           push_ok;
	logic           push;

	// Classify the command; drop the unused code
	always_comb begin
		push_kind = OP_APPEND_A;
		push_ok   = 1'b0;
		case (request.command)
			CMD_APPEND_FIRST: begin
				push_kind = OP_APPEND_A;
				push_ok   = 1'b1;
			end
			CMD_APPEND_SECOND: begin
				push_kind = OP_APPEND_B;
				push_ok   = 1'b1;
			end
			CMD_COMPARE: begin
				push_kind = OP_COMPARE;
				push_ok   = 1'b1;
			end
			default: begin
				push_ok = 1'b0;
			end
		endcase
	end

	assign busy = (count_q == QCW'(QDEPTH));
	assign push = start && !busy && push_ok;

	// Store queued operations
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{kind: push_kind, ch: request.character};
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push, take})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != '0);
	assign head.op    = fifo_q[rd_ptr_q];

`ifndef SYNTH
	a_take_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> count_q != '0)
		else $error("queue popped while empty");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("queue count above depth");
`endif

endmodule

@@ hdl/nosc_back.sv @@
module nosc_back import nosc_pkg::*; #(
	parameter int MAX_LEN = DEF_MAX_LEN
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    case_fold,
	input  q_head_t head,
	output logic    take,
	output logic    done,
	output res_t    result
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam logic [7:0] CH_ZERO = 8'h30;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_FETCH  = 5'b00010,
		S_MAIN   = 5'b00100,
		S_RFETCH = 5'b01000,
		S_RUN    = 5'b10000
	} state_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
	endfunction

	function automatic logic [7:0] upper(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) ? (c - 8'h20) : c;
	endfunction

	logic [7:0]    mem_a [MAX_LEN];
	logic [7:0]    mem_b [MAX_LEN];
	state_t        state_q;
	logic [LW-1:0] len_a_q, len_b_q;
	logic          ovf_q;
	logic [LW-1:0] pa_q, pb_q;
	logic [LW-1:0] ia_q, ib_q;
	logic          left_q;
	logic [1:0]    lean_q;
	logic [7:0]    rd_a_q, rd_b_q;
	logic          ok_a_q, ok_b_q;
	logic          done_q;
	res_t          res_q;

	logic [7:0] x, y, xf, yf;
	logic       dx, dy, sx, sy;
	logic       sgn_lt, sgn_gt;
	logic       wr_a, wr_b, room_a, room_b;
	logic       fin;
	logic [1:0] fin_ord;

	// Characters at the walk positions; past the end reads as NUL
	assign x  = ok_a_q ? rd_a_q : 8'h00;
	assign y  = ok_b_q ? rd_b_q : 8'h00;
	assign xf = case_fold ? upper(x) : x;
	assign yf = case_fold ? upper(y) : y;
	assign dx = is_digit(x);
	assign dy = is_digit(y);
	assign sx = is_space(x);
	assign sy = is_space(y);
	assign sgn_lt = $signed(xf) < $signed(yf);
	assign sgn_gt = $signed(xf) > $signed(yf);

	assign take   = (state_q == S_IDLE) && head.valid;
	assign room_a = len_a_q < LW'(MAX_LEN);
	assign room_b = len_b_q < LW'(MAX_LEN);
	assign wr_a   = take && (head.op.kind == OP_APPEND_A) && room_a;
	assign wr_b   = take && (head.op.kind == OP_APPEND_B) && room_b;

	// Write appended characters
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[len_a_q[AW-1:0]] <= head.op.ch;
		end
		if (wr_b) begin
			mem_b[len_b_q[AW-1:0]] <= head.op.ch;
		end
	end

	// Read both buffers at the walk positions
	always_ff @(posedge clk) begin
		rd_a_q <= mem_a[pa_q[AW-1:0]];
		rd_b_q <= mem_b[pb_q[AW-1:0]];
		ok_a_q <= pa_q < len_a_q;
		ok_b_q <= pb_q < len_b_q;
	end

	// Decide whether this step settles the order
	always_comb begin
		fin     = 1'b0;
		fin_ord = ORD_EQ;
		case (state_q)
			S_MAIN: begin
				if (!sx && !sy && !(dx && dy)) begin
					if (x == 8'h00 && y == 8'h00) begin
						fin = 1'b1;
					end else if (sgn_lt) begin
						fin     = 1'b1;
						fin_ord = ORD_LT;
					end else if (sgn_gt) begin
						fin     = 1'b1;
						fin_ord = ORD_GT;
					end
				end
			end
			S_RUN: begin
				if (!dx && !dy) begin
					if (!left_q && lean_q != ORD_EQ) begin
						fin     = 1'b1;
						fin_ord = lean_q;
					end
				end else if (!dx) begin
					fin     = 1'b1;
					fin_ord = ORD_LT;
				end else if (!dy) begin
					fin     = 1'b1;
					fin_ord = ORD_GT;
				end else if (left_q && x != y) begin
					fin     = 1'b1;
					fin_ord = (x < y) ? ORD_LT : ORD_GT;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Sequence appends and the compare walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_a_q <= '0;
			len_b_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (fin) begin
				done_q  <= 1'b1;
				len_a_q <= '0;
				len_b_q <= '0;
				ovf_q   <= 1'b0;
				state_q <= S_IDLE;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (take) begin
							case (head.op.kind)
								OP_APPEND_A: begin
									if (room_a) len_a_q <= len_a_q + LW'(1);
									else ovf_q <= 1'b1;
								end
								OP_APPEND_B: begin
									if (room_b) len_b_q <= len_b_q + LW'(1);
									else ovf_q <= 1'b1;
								end
								OP_COMPARE: begin
									state_q <= S_FETCH;
								end
								default: begin
									state_q <= S_IDLE;
								end
							endcase
						end
					end
					S_FETCH:  state_q <= S_MAIN;
					S_RFETCH: state_q <= S_RUN;
					S_MAIN: begin
						if (dx && dy && !sx && !sy) begin
							state_q <= S_RFETCH;
						end else begin
							state_q <= S_FETCH;
						end
					end
					S_RUN: begin
						if (!dx && !dy) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_RFETCH;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	// Move the walk positions and track digit runs
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q.order     <= fin_ord;
			res_q.truncated <= ovf_q;
		end
		case (state_q)
			S_IDLE: begin
				pa_q <= '0;
				pb_q <= '0;
			end
			S_MAIN: begin
				if (sx || sy) begin
					if (sx) pa_q <= pa_q + LW'(1);
					if (sy) pb_q <= pb_q + LW'(1);
				end else if (dx && dy) begin
					ia_q   <= pa_q;
					ib_q   <= pb_q;
					left_q <= (x == CH_ZERO) || (y == CH_ZERO);
					lean_q <= ORD_EQ;
				end else begin
					pa_q <= pa_q + LW'(1);
					pb_q <= pb_q + LW'(1);
				end
			end
			S_RUN: begin
				if (!dx && !dy) begin
					// Runs tie: the leading digits match, step past them
					pa_q <= ia_q + LW'(1);
					pb_q <= ib_q + LW'(1);
				end else begin
					if (!left_q && lean_q == ORD_EQ && x != y) begin
						lean_q <= (x < y) ? ORD_LT : ORD_GT;
					end
					pa_q <= pa_q + LW'(1);
					pb_q <= pb_q + LW'(1);
				end
			end
			default: begin
				pa_q <= pa_q;
				pb_q <= pb_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTH
	a_clear_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (len_a_q == '0 && len_b_q == '0 && !ovf_q && state_q == S_IDLE))
		else $error("strings not cleared with result");

	a_walk_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (pa_q <= len_a_q && pb_q <= len_b_q))
		else $error("walk position past stored length");

	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (res_q.order == ORD_LT || res_q.order == ORD_EQ ||
			res_q.order == ORD_GT))
		else $error("bad order code");

	a_no_take_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !take)
		else $error("queue popped during compare");
`endif

endmodule

@@ hdl/natural_order_string_compare.sv @@
// Appends: one per cycle sustained while the engine is idle and the queue is not full;
// a command is registered in the queue before the engine takes it. Compare: each walk step
// reads both buffers (one registered read port each); a tied digit run is walked again
// from its next digit. A four-entry command queue keeps start open during a compare
// until full. Results are a one-cycle done strobe; the receiver cannot stall.
// arst_n clears lengths, truncation flag, queue and case-fold setting; buffers are kept.
module natural_order_string_compare import nosc_pkg::*; #(
	parameter int MAX_LEN = DEF_MAX_LEN
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic done,
	output res_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	q_head_t head;
	logic    take;
	logic    case_fold_q;

	// Hold the case-fold setting
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_fold_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case_fold_q <= cfg_data;
		end
	end

	nosc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.take    (take),
		.head    (head)
	);

	nosc_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.case_fold (case_fold_q),
		.head      (head),
		.take      (take),
		.done      (done),
		.result    (result)
	);

endmodule
